// ===== rtl/pass_hazard_dependency_tracker_macros.svh =====
// Assertion macros for the pass hazard dependency tracker.
// Used by the checker; expects clock and reset in the calling scope.
`ifndef PASS_HAZARD_DEPENDENCY_TRACKER_MACROS_SVH
`define PASS_HAZARD_DEPENDENCY_TRACKER_MACROS_SVH

// same-cycle implication, off during reset
`define PHDT_ASSERT_IMM(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("phdt assertion failed");

// next-cycle implication, off during reset
`define PHDT_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("phdt assertion failed");

// next-cycle implication, also checked across reset
`define PHDT_ASSERT_RST(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("phdt assertion failed");

`endif

// ===== rtl/phdt_pkg.sv =====
// Package for the pass hazard dependency tracker: field widths and access kind codes.
// No dependencies.
`timescale 1ns / 1ps

package phdt_pkg;

   localparam int RID_W  = 16;
   localparam int KIND_W = 2;
   localparam int SLOT_W = 4;
   localparam int MASK_W = 16;

   localparam logic [KIND_W-1:0] KIND_READ  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RDWR  = 2'd2;

endpackage

// ===== rtl/phdt_ifs.sv =====
// Request and response channel interfaces of the pass hazard dependency tracker.
// Depends on phdt_pkg.
`timescale 1ns / 1ps

interface phdt_req_if;
   import phdt_pkg::*;

   logic              valid;
   logic              ready;
   logic [RID_W-1:0]  resource_id;
   logic [KIND_W-1:0] access_kind;
   logic              has_access;
   logic              last_access;
   logic              new_graph;

   modport source (output valid, resource_id, access_kind, has_access, last_access,
                   new_graph, input ready);
   modport sink   (input valid, resource_id, access_kind, has_access, last_access,
                   new_graph, output ready);
endinterface

interface phdt_rsp_if;
   import phdt_pkg::*;

   logic              valid;
   logic              ready;
   logic [SLOT_W-1:0] pass_slot;
   logic [MASK_W-1:0] dependency_mask;
   logic              overflow;

   modport source (output valid, pass_slot, dependency_mask, overflow, input ready);
   modport sink   (input valid, pass_slot, dependency_mask, overflow, output ready);
endinterface

// ===== rtl/pass_hazard_dependency_tracker.sv =====
// Channel   Dir  Handshake         Payload
// req_ch    in   valid / ready     resource_id, access_kind, has_access, last_access, new_graph
// rsp_ch    out  valid / ready     pass_slot, dependency_mask, overflow
//
// A request with an access scans all stored accesses of closed passes through one store
// read port and one comparator, is then stored, and closes its pass if it is the last.
// Dropped or empty requests skip the scan. Synchronous reset clears the state, pass and
// access counts, mask, overflow and valid flags; the scan counters are loaded on each
// accepted request, and the access store is read only where written. A waiting response
// holds the close.
// Depends on phdt_pkg and phdt_ifs.
`timescale 1ns / 1ps

module pass_hazard_dependency_tracker #(
   parameter int MAX_PASSES    = 16,
   parameter int MAX_ACCESSES  = 8,
   parameter int RESOURCE_BITS = 16
) (
   input logic          clock,
   input logic          reset,
   phdt_req_if.sink     req_ch,
   phdt_rsp_if.source   rsp_ch
);
   import phdt_pkg::*;

   localparam int RES_W = (RESOURCE_BITS < RID_W) ? RESOURCE_BITS : RID_W;
   localparam int PCW   = $clog2(MAX_PASSES + 1);
   localparam int PW    = $clog2(MAX_PASSES);
   localparam int ACW   = $clog2(MAX_ACCESSES + 1);
   localparam int AW    = (MAX_ACCESSES > 1) ? $clog2(MAX_ACCESSES) : 1;
   localparam int DEPTH = MAX_PASSES * MAX_ACCESSES;
   localparam int SAW   = $clog2(DEPTH);
   localparam int BW    = $clog2(DEPTH + 1);
   localparam int MXW   = (MAX_PASSES > MASK_W) ? MAX_PASSES : MASK_W;
   localparam int SXW   = (PCW > SLOT_W) ? PCW : SLOT_W;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_STORE  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type              state_ff, state_in;
   logic [RES_W-1:0]       res_ff, res_in;
   logic                   wr_ff, wr_in;
   logic                   last_ff, last_in;
   logic [PCW-1:0]         pass_cnt_ff, pass_cnt_in;
   logic [ACW-1:0]         pend_ff, pend_in;
   logic [MAX_PASSES-1:0]  mask_ff, mask_in;
   logic                   ovf_ff, ovf_in;
   logic [BW-1:0]          base_ff, base_in;
   logic [BW-1:0]          addr_ff, addr_in;
   logic [AW-1:0]          a_ff, a_in;
   logic [PW-1:0]          p_ff, p_in;
   logic                   s1_vld_ff, s1_vld_in;
   logic [AW-1:0]          s1_a_ff, s1_a_in;
   logic [PW-1:0]          s1_p_ff, s1_p_in;
   logic                   rsp_vld_ff, rsp_vld_in;
   logic [SLOT_W-1:0]      slot_ff, slot_in;
   logic [MASK_W-1:0]      dmask_ff, dmask_in;
   logic                   rovf_ff, rovf_in;

   logic [RES_W-1:0]       store_res [DEPTH];
   logic                   store_wr  [DEPTH];
   logic [ACW-1:0]         cnt_mem   [MAX_PASSES];
   logic [RES_W-1:0]       rd_res_ff;
   logic                   rd_wr_ff;
   logic [ACW-1:0]         rd_cnt_ff;

   logic                   mem_we;
   logic                   cnt_we;
   logic                   hit;
   logic [BW-1:0]          waddr;
   logic [MXW-1:0]         mask_ext;
   logic [SXW-1:0]         slot_ext;

   assign waddr    = base_ff + BW'(pend_ff);
   assign mask_ext = MXW'(mask_ff);
   assign slot_ext = SXW'(pass_cnt_ff);
   assign hit      = s1_vld_ff && (ACW'(s1_a_ff) < rd_cnt_ff) && (rd_res_ff == res_ff)
                     && (wr_ff || rd_wr_ff);

   assign req_ch.ready           = (state_ff == ST_IDLE);
   assign rsp_ch.valid           = rsp_vld_ff;
   assign rsp_ch.pass_slot       = slot_ff;
   assign rsp_ch.dependency_mask = dmask_ff;
   assign rsp_ch.overflow        = rovf_ff;

   always_comb begin
      logic [PCW-1:0] pc_eff;
      logic [ACW-1:0] pend_eff;

      state_in    = state_ff;
      res_in      = res_ff;
      wr_in       = wr_ff;
      last_in     = last_ff;
      pass_cnt_in = pass_cnt_ff;
      pend_in     = pend_ff;
      mask_in     = mask_ff;
      ovf_in      = ovf_ff;
      base_in     = base_ff;
      addr_in     = addr_ff;
      a_in        = a_ff;
      p_in        = p_ff;
      s1_vld_in   = 1'b0;
      s1_a_in     = a_ff;
      s1_p_in     = p_ff;
      rsp_vld_in  = rsp_vld_ff & ~rsp_ch.ready;
      slot_in     = slot_ff;
      dmask_in    = dmask_ff;
      rovf_in     = rovf_ff;
      mem_we      = 1'b0;
      cnt_we      = 1'b0;
      pc_eff      = pass_cnt_ff;
      pend_eff    = pend_ff;

      if (hit) begin
         mask_in[s1_p_ff] = 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               res_in  = req_ch.resource_id[RES_W-1:0];
               wr_in   = (req_ch.access_kind == KIND_WRITE)
                         || (req_ch.access_kind == KIND_RDWR);
               last_in = req_ch.last_access;
               if (req_ch.new_graph) begin
                  pc_eff      = '0;
                  pend_eff    = '0;
                  pass_cnt_in = '0;
                  pend_in     = '0;
                  mask_in     = '0;
                  ovf_in      = 1'b0;
                  base_in     = '0;
               end
               addr_in = '0;
               a_in    = '0;
               p_in    = '0;
               if (!req_ch.has_access) begin
                  state_in = ST_FINISH;
               end else if (pc_eff == PCW'(MAX_PASSES) || pend_eff == ACW'(MAX_ACCESSES)) begin
                  ovf_in   = 1'b1;
                  state_in = req_ch.last_access ? ST_FINISH : ST_IDLE;
               end else begin
                  state_in = (pc_eff == '0) ? ST_STORE : ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            s1_vld_in = 1'b1;
            s1_a_in   = a_ff;
            s1_p_in   = p_ff;
            addr_in   = addr_ff + BW'(1);
            if (a_ff == AW'(MAX_ACCESSES - 1)) begin
               a_in = '0;
               p_in = p_ff + PW'(1);
            end else begin
               a_in = a_ff + AW'(1);
            end
            if (addr_ff == base_ff - BW'(1)) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            mem_we   = 1'b1;
            pend_in  = pend_ff + ACW'(1);
            state_in = last_ff ? ST_FINISH : ST_IDLE;
         end
         ST_FINISH: begin
            if (!rsp_vld_ff || rsp_ch.ready) begin
               rsp_vld_in = 1'b1;
               if (pass_cnt_ff == PCW'(MAX_PASSES)) begin
                  ovf_in   = 1'b1;
                  slot_in  = '0;
                  dmask_in = '0;
                  rovf_in  = 1'b1;
               end else begin
                  cnt_we      = 1'b1;
                  slot_in     = slot_ext[SLOT_W-1:0];
                  dmask_in    = mask_ext[MASK_W-1:0];
                  rovf_in     = ovf_ff;
                  pass_cnt_in = pass_cnt_ff + PCW'(1);
                  base_in     = base_ff + BW'(MAX_ACCESSES);
               end
               pend_in  = '0;
               mask_in  = '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         pass_cnt_ff <= '0;
         pend_ff     <= '0;
         mask_ff     <= '0;
         ovf_ff      <= 1'b0;
         base_ff     <= '0;
         s1_vld_ff   <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         pass_cnt_ff <= pass_cnt_in;
         pend_ff     <= pend_in;
         mask_ff     <= mask_in;
         ovf_ff      <= ovf_in;
         base_ff     <= base_in;
         s1_vld_ff   <= s1_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff   <= res_in;
      wr_ff    <= wr_in;
      last_ff  <= last_in;
      addr_ff  <= addr_in;
      a_ff     <= a_in;
      p_ff     <= p_in;
      s1_a_ff  <= s1_a_in;
      s1_p_ff  <= s1_p_in;
      slot_ff  <= slot_in;
      dmask_ff <= dmask_in;
      rovf_ff  <= rovf_in;
   end

   // access store and per-pass access counts, registered reads
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_res[waddr[SAW-1:0]] <= res_ff;
         store_wr[waddr[SAW-1:0]]  <= wr_ff;
      end
      rd_res_ff <= store_res[addr_ff[SAW-1:0]];
      rd_wr_ff  <= store_wr[addr_ff[SAW-1:0]];
      if (cnt_we) begin
         cnt_mem[pass_cnt_ff[PW-1:0]] <= pend_ff;
      end
      rd_cnt_ff <= cnt_mem[p_ff];
   end

endmodule

// ===== rtl/phdt_checker.sv =====
// Port-level checker for the pass hazard dependency tracker, with its bind statement.
// Depends on phdt_pkg and pass_hazard_dependency_tracker_macros.svh.
`timescale 1ns / 1ps
`include "pass_hazard_dependency_tracker_macros.svh"

module phdt_checker #(
   parameter int MAX_PASSES = 16
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       req_has_access,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [phdt_pkg::SLOT_W-1:0] rsp_pass_slot,
   input logic [phdt_pkg::MASK_W-1:0] rsp_dependency_mask,
   input logic                       rsp_overflow
);
   import phdt_pkg::*;

   `PHDT_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_pass_slot) && $stable(rsp_dependency_mask) && $stable(rsp_overflow))
   `PHDT_ASSERT_IMM(a_mask_backward, rsp_valid && (MAX_PASSES <= MASK_W), (rsp_dependency_mask >> rsp_pass_slot) == '0)
   `PHDT_ASSERT_NXT(a_empty_close_busy, req_valid && req_ready && !req_has_access, !req_ready)
   `PHDT_ASSERT_RST(a_reset_idle, reset, !rsp_valid)

endmodule

bind pass_hazard_dependency_tracker phdt_checker #(
   .MAX_PASSES (MAX_PASSES)
) u_phdt_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_ch.valid),
   .req_ready           (req_ch.ready),
   .req_has_access      (req_ch.has_access),
   .rsp_valid           (rsp_ch.valid),
   .rsp_ready           (rsp_ch.ready),
   .rsp_pass_slot       (rsp_ch.pass_slot),
   .rsp_dependency_mask (rsp_ch.dependency_mask),
   .rsp_overflow        (rsp_ch.overflow)
);

// ===== bench/tb_pass_hazard_dependency_tracker.sv =====
// Self-checking bench for pass_hazard_dependency_tracker: directed and random pass sequences.
// A hazard board tracks stored accesses, predicts each closed pass and checks the responses.
// Depends on phdt_pkg, phdt_ifs and the tracker RTL.
`timescale 1ns / 1ps

module tb_pass_hazard_dependency_tracker;
   import phdt_pkg::*;

   localparam int NUM_PASSES    = 16;
   localparam int NUM_ACCESSES  = 8;
   localparam int STORE_DEPTH   = NUM_PASSES * NUM_ACCESSES;
   localparam int REQUEST_COUNT = 1100;
   localparam int CALM_TAIL     = 150;
   localparam int DRAIN_CYCLES  = 200;
   localparam int CYCLE_LIMIT   = 1_000_000;

   localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

   typedef struct packed {
      logic [RID_W-1:0]  resource_id;
      logic [KIND_W-1:0] access_kind;
      logic              has_access;
      logic              last_access;
      logic              new_graph;
   } request_type;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic [MASK_W-1:0] mask;
      logic              overflow;
   } close_type;

   class hazard_board;
      logic [RID_W-1:0] rid_store [STORE_DEPTH];
      bit               write_store [STORE_DEPTH];
      int unsigned      pass_len [NUM_PASSES];
      int unsigned      closed;
      logic [MASK_W-1:0] open_mask;
      int unsigned      open_len;
      bit               dropped;
      close_type        pending_closes [$];
      int unsigned      errors;

      function new();
         errors = 0;
         clear_graph();
      endfunction

      function void clear_graph();
         foreach (pass_len[p]) pass_len[p] = 0;
         closed    = 0;
         open_mask = '0;
         open_len  = 0;
         dropped   = 1'b0;
      endfunction

      function void add_access(logic [RID_W-1:0] rid, bit writes);
         int unsigned idx;
         if (closed >= NUM_PASSES || open_len >= NUM_ACCESSES) begin
            dropped = 1'b1;
            return;
         end
         for (int unsigned p = 0; p < closed; p++) begin
            for (int unsigned a = 0; a < pass_len[p]; a++) begin
               idx = p * NUM_ACCESSES + a;
               if (rid_store[idx] == rid && (writes || write_store[idx]))
                  open_mask[p] = 1'b1;
            end
         end
         idx = closed * NUM_ACCESSES + open_len;
         rid_store[idx]   = rid;
         write_store[idx] = writes;
         open_len++;
      endfunction

      function void close_pass();
         close_type c;
         if (closed >= NUM_PASSES) begin
            dropped    = 1'b1;
            c.slot     = '0;
            c.mask     = '0;
            c.overflow = 1'b1;
         end else begin
            pass_len[closed] = open_len;
            c.slot           = SLOT_W'(closed);
            c.mask           = open_mask;
            c.overflow       = dropped;
            closed++;
         end
         open_mask = '0;
         open_len  = 0;
         pending_closes = {pending_closes, c};
      endfunction

      function void note_request(request_type r);
         if (r.new_graph)
            clear_graph();
         if (!r.has_access) begin
            close_pass();
            return;
         end
         add_access(r.resource_id, r.access_kind == KIND_WRITE || r.access_kind == KIND_RDWR);
         if (r.last_access)
            close_pass();
      endfunction

      function void check_close(close_type got);
         close_type want;
         if (pending_closes.size() == 0) begin
            errors++;
            $display("%0t: response with none expected: slot %0d mask %h overflow %0d",
                     $time, got.slot, got.mask, got.overflow);
            return;
         end
         want = pending_closes.pop_front();
         if (got.slot !== want.slot) begin
            errors++;
            $display("%0t: pass_slot expected %0d actual %0d", $time, want.slot, got.slot);
         end
         if (got.mask !== want.mask) begin
            errors++;
            $display("%0t: dependency_mask expected %h actual %h", $time, want.mask, got.mask);
         end
         if (got.overflow !== want.overflow) begin
            errors++;
            $display("%0t: overflow expected %0d actual %0d", $time, want.overflow,
                     got.overflow);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   bit          idle_on = 1'b1;
   int unsigned sent = 0;
   int unsigned cycles = 0;
   hazard_board board;

   phdt_req_if req_ch ();
   phdt_rsp_if rsp_ch ();

   pass_hazard_dependency_tracker i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_pass_hazard_dependency_tracker: FAIL");
         $finish;
      end
   end

   task automatic send_request(logic [RID_W-1:0] rid, logic [KIND_W-1:0] kind, bit has,
                               bit last, bit fresh);
      request_type r;
      r = '{rid, kind, has, last, fresh};
      if (idle_on && $urandom_range(0, 7) == 0) begin
         req_ch.valid = 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_ch.valid       = 1'b1;
      req_ch.resource_id = rid;
      req_ch.access_kind = kind;
      req_ch.has_access  = has;
      req_ch.last_access = last;
      req_ch.new_graph   = fresh;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      board.note_request(r);
      sent++;
      @(negedge clock);
   endtask

   // well-formed graph: fresh start, passes drawn mostly from a small resource pool
   task automatic send_graph();
      int unsigned      npass;
      int unsigned      nacc;
      int unsigned      pool_n;
      logic [RID_W-1:0] pool [6];
      logic [RID_W-1:0] rid;
      bit               first;
      pool_n = $urandom_range(1, 6);
      foreach (pool[i]) pool[i] = RID_W'($urandom());
      npass = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 20) : $urandom_range(1, 10);
      first = 1'b1;
      for (int p = 0; p < npass; p++) begin
         if ($urandom_range(0, 11) == 0) begin
            send_request(RID_W'($urandom()), KIND_W'($urandom_range(0, 3)), 1'b0,
                         1'($urandom_range(0, 1)), first);
            first = 1'b0;
         end else begin
            nacc = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 10) : $urandom_range(1, 4);
            for (int a = 0; a < nacc; a++) begin
               rid = ($urandom_range(0, 9) == 0) ? RID_W'($urandom())
                                                 : pool[$urandom_range(0, pool_n - 1)];
               send_request(rid, KIND_W'($urandom_range(0, 3)), 1'b1, a == nacc - 1, first);
               first = 1'b0;
            end
         end
      end
   endtask

   task automatic send_noise();
      int unsigned n;
      n = $urandom_range(1, 8);
      repeat (n)
         send_request(RID_W'($urandom()), KIND_W'($urandom_range(0, 3)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      $urandom_range(0, 5) == 0);
   endtask

   initial begin
      int unsigned stall_left;
      stall_left   = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_ch.ready = 1'b0;
            stall_left--;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_ch.ready = 1'b0;
            stall_left   = $urandom_range(0, 16);
         end else begin
            rsp_ch.ready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
         board.check_close('{rsp_ch.pass_slot, rsp_ch.dependency_mask, rsp_ch.overflow});
   end

   initial begin
      board              = new();
      req_ch.valid       = 1'b0;
      req_ch.resource_id = '0;
      req_ch.access_kind = KIND_READ;
      req_ch.has_access  = 1'b0;
      req_ch.last_access = 1'b0;
      req_ch.new_graph   = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_request(16'h0000, KIND_READ,  1'b1, 1'b1, 1'b1);
      send_request(16'hFFFF, KIND_WRITE, 1'b1, 1'b0, 1'b0);
      send_request(16'h0000, KIND_SPARE, 1'b1, 1'b1, 1'b0);  // spare kind reads
      send_request(16'h0000, KIND_WRITE, 1'b1, 1'b1, 1'b0);
      send_request(16'hFFFF, KIND_RDWR,  1'b1, 1'b1, 1'b0);
      send_request(16'hFFFF, KIND_SPARE, 1'b0, 1'b0, 1'b0);  // empty pass
      for (int i = 0; i <= NUM_ACCESSES; i++)               // one access too many
         send_request(RID_W'(i), KIND_WRITE, 1'b1, i == NUM_ACCESSES, 1'b0);
      repeat (10) send_request(16'h5A5A, KIND_READ, 1'b0, 1'b1, 1'b0);
      send_request(16'h0000, KIND_WRITE, 1'b1, 1'b1, 1'b0);  // graph full
      send_request(16'h0000, KIND_READ,  1'b0, 1'b0, 1'b1);  // fresh graph, empty pass

      while (sent < REQUEST_COUNT) begin
         idle_on = sent < REQUEST_COUNT - CALM_TAIL;
         if ($urandom_range(0, 6) == 0)
            send_noise();
         else
            send_graph();
      end
      req_ch.valid = 1'b0;
      idle_on      = 1'b0;

      while (board.pending_closes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0)
         $display("tb_pass_hazard_dependency_tracker: PASS");
      else
         $display("tb_pass_hazard_dependency_tracker: FAIL");
      $finish;
   end

endmodule

// ===== pass_hazard_dependency_tracker.f =====
+incdir+rtl
rtl/phdt_pkg.sv
rtl/phdt_ifs.sv
rtl/pass_hazard_dependency_tracker.sv
rtl/phdt_checker.sv
bench/tb_pass_hazard_dependency_tracker.sv
